[src/gffc_pkg.sv]
// ----------------------------------------------------------------------------
// gffc_pkg: shared constants for the greedy first-fit coloring block
// Sizes of the node index, the color store and the configuration register.
// ----------------------------------------------------------------------------
`default_nettype none

package gffc_pkg;

  // Largest graph the color store can hold (2 to 16).
  localparam int MAX_NODES = 16;

  // Node index width and the width that can hold MAX_NODES itself.
  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);

  // Conflict row width and the width of an index into it.
  localparam int IN_BITS  = 16;
  localparam int IN_IDX_W = $clog2(IN_BITS);

  // Colors are four bits; the used-color mask has one bit per color.
  localparam int COLOR_W = 4;
  localparam int USED_W  = 1 << COLOR_W;

  // Configuration register and the width used to compare counts.
  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] COUNT_RESET = CFG_W'(16);
  localparam int CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

  // Width of a scan limit, which can reach min(MAX_NODES - 1, IN_BITS).
  localparam int LIM_W = NODE_W + 1;

  // Output payload width: node index then color, padded to whole bytes.
  localparam int OUT_W = 8;

endpackage : gffc_pkg

`default_nettype wire

[src/gffc_ram.sv]
// ----------------------------------------------------------------------------
// gffc_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gffc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : gffc_ram

`default_nettype wire

[src/greedy_first_fit_coloring_top.sv]
// ----------------------------------------------------------------------------
// greedy_first_fit_coloring_top: greedy first-fit graph coloring
// Colors one node per request from its conflict row, keeping colors in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the in_ channel carries the conflict row of the next
//   node; bit q set means the node conflicts with node q. Only nodes that
//   come earlier in the current graph are considered. The block answers
//   each request with one result on the out_ channel: the node index, the
//   smallest color no earlier conflicting neighbor holds, and tlast on the
//   final node of the graph. After that node the counter returns to zero.
//   cfg_wr_en writes node_count (0 acts as 1, values above the store size
//   saturate); write it only while no request is in flight.
// Timing:
//   The color store is a one-port-read RAM, and the scan reads one earlier
//   color per cycle. After acceptance, node n (n > 0) scans min(n, 16)
//   earlier nodes, then drains the last read and loads its result; node 0
//   goes straight to loading its result. A new request is accepted only
//   after the result of the previous one is loaded.
// Reset and stall:
//   rst_n (synchronous) clears the node counter and sets node_count to 16;
//   the RAM is not cleared, since only entries written earlier in the
//   same graph are ever read. A result waits in the output register while
//   out_tready is low and the next request may still be accepted and
//   scanned; it only stalls before its own result is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_first_fit_coloring_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Configuration: node_count
  input  wire logic                       cfg_wr_en,
  input  wire logic [gffc_pkg::CFG_W-1:0] cfg_wr_data,
  // Input requests
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [15:0]                in_tdata,   // [15:0] neighbor_bits
  // Results
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [gffc_pkg::OUT_W-1:0]      out_tdata,  // [3:0] node_index, [7:4] node_color
  output logic                            out_tlast   // last_node
);

  import gffc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t                 state_r,   state_nxt;
  logic [CFG_W-1:0]       count_r,   count_nxt;
  logic [NODE_W-1:0]      node_r,    node_nxt;     // node being colored
  logic [NODE_W-1:0]      ctr_r,     ctr_nxt;      // next node of the graph
  logic [NODE_W-1:0]      q_r,       q_nxt;        // scan address
  logic [IN_BITS-1:0]     row_r,     row_nxt;
  logic [USED_W-1:0]      used_r,    used_nxt;
  logic                   pend_r,    pend_nxt;     // a read returns this cycle
  logic                   pbit_r,    pbit_nxt;     // row bit of that read
  logic                   ovalid_r,  ovalid_nxt;
  logic [OUT_W-1:0]       odata_r,   odata_nxt;
  logic                   olast_r,   olast_nxt;

  logic                   in_acc;
  logic                   slot_free;
  logic                   ram_we;
  logic [COLOR_W-1:0]     ram_rdata;
  logic [COLOR_W-1:0]     color;
  logic                   last;
  logic [LIM_W-1:0]       lim;
  logic [LIM_W-1:0]       q_inc;
  logic [CMP_W-1:0]       eff_count;
  logic [CMP_W-1:0]       node_plus1;
  logic [USED_W-1:0]      used_acc;

  gffc_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (MAX_NODES)
  ) u_color_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (node_r),
    .wdata (color),
    .raddr (q_r),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign slot_free  = !ovalid_r || out_tready;
  assign ram_we     = (state_r == ST_FINISH) && slot_free;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  // Fold in the color returned by the previous read when its row bit is set.
  assign used_acc = (pend_r && pbit_r) ? (used_r | (USED_W'(1) << ram_rdata)) : used_r;

  // Only the first IN_BITS earlier nodes have a row bit.
  assign lim   = (LIM_W'(node_r) < LIM_W'(IN_BITS)) ? LIM_W'(node_r) : LIM_W'(IN_BITS);
  assign q_inc = LIM_W'(q_r) + LIM_W'(1);

  // Effective node count: zero acts as one, large values saturate.
  always_comb begin
    if (count_r == '0) begin
      eff_count = CMP_W'(1);
    end else if (CMP_W'(count_r) > CMP_W'(MAX_NODES)) begin
      eff_count = CMP_W'(MAX_NODES);
    end else begin
      eff_count = CMP_W'(count_r);
    end
  end

  assign node_plus1 = CMP_W'(node_r) + CMP_W'(1);
  assign last       = (node_plus1 >= eff_count);

  // First free color; saturates at the top color when all are taken.
  always_comb begin
    logic found;
    found = 1'b0;
    color = COLOR_W'(USED_W - 1);
    for (int i = 0; i < USED_W; i++) begin
      if (!found && !used_r[i]) begin
        color = COLOR_W'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = cfg_wr_en ? cfg_wr_data : count_r;
    node_nxt   = node_r;
    ctr_nxt    = ctr_r;
    q_nxt      = q_r;
    row_nxt    = row_r;
    used_nxt   = used_acc;
    pend_nxt   = 1'b0;
    pbit_nxt   = 1'b0;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          node_nxt  = ctr_r;
          row_nxt   = in_tdata;
          used_nxt  = '0;
          q_nxt     = '0;
          state_nxt = (ctr_r == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Read the color of node q this cycle; it arrives next cycle.
        pend_nxt = 1'b1;
        pbit_nxt = row_r[IN_IDX_W'(q_r)];
        q_nxt    = q_r + NODE_W'(1);
        if (q_inc >= lim) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = {color, COLOR_W'(node_r)};
          olast_nxt  = last;
          ctr_nxt    = last ? '0 : (node_r + NODE_W'(1));
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= COUNT_RESET;
      ctr_r    <= '0;
      pend_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ctr_r    <= ctr_nxt;
      pend_r   <= pend_nxt;
      ovalid_r <= ovalid_nxt;
    end
    node_r  <= node_nxt;
    q_r     <= q_nxt;
    row_r   <= row_nxt;
    used_r  <= used_nxt;
    pbit_r  <= pbit_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

  // Assertions

  // The color store is only written when the result can be loaded.
  a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> ovalid_r && (odata_r[COLOR_W-1:0] == COLOR_W'(node_r)))
    else $error("color store write without matching result");

  // Node zero of every graph gets color zero.
  a_node0_color0: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && (node_r == '0)) |-> (color == '0))
    else $error("node zero colored nonzero");

  // A result marked last restarts the graph at node zero.
  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && last) |=> (ctr_r == '0))
    else $error("node counter did not wrap after last node");

  // Scanning never reads at or beyond the node being colored.
  a_scan_below_node: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (q_r < node_r))
    else $error("scan address reached the current node");

endmodule : greedy_first_fit_coloring_top

`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for greedy_first_fit_coloring_top
// Streams conflict rows into the block and predicts every colored node with
// its own first-fit model. Each result is checked field by field in order.
// The run covers many node_count settings, partial graphs, and random
// back-pressure on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import gffc_pkg::*;

  // A cycle count with no handshake on either channel that means the block hung.
  localparam int STALL_LIMIT = 3000;
  // Requests to send in the random part.
  localparam int RANDOM_ROWS = 1900;

  // One colored node as it appears on the result channel.
  typedef struct packed {
    logic [3:0] node;
    logic [3:0] color;
    logic       last;
  } coloring_t;

  // How dense the conflict rows of one graph are.
  typedef enum int {ROW_ANY, ROW_SPARSE, ROW_DENSE, ROW_FULL} row_mix_t;

  logic             clk;
  logic             rst_n       = 1'b0;
  logic             cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic             in_tvalid   = 1'b0;
  logic             in_tready;
  logic [15:0]      in_tdata    = '0;   // [15:0] neighbor_bits
  logic             out_tvalid;
  logic             out_tready  = 1'b0;
  logic [OUT_W-1:0] out_tdata;          // [3:0] node_index, [7:4] node_color
  logic             out_tlast;          // last_node

  // Rows waiting to be offered, and colorings predicted for accepted requests.
  logic [15:0] row_queue[$];
  coloring_t   colorings_due[$];

  // Predictor state: our own copy of the color store, node counter and
  // node_count register. Reset is applied once, so the initial values stand.
  logic [3:0]       color_mem[MAX_NODES];
  int               next_node = 0;
  logic [CFG_W-1:0] count_reg = COUNT_RESET;

  int error_count  = 0;
  int stall_cycles = 0;
  bit no_gaps      = 1'b0;

  greedy_first_fit_coloring_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Colors the next node from its conflict row and advances the predictor.
  // A count of zero acts as one and a count above the store size saturates.
  // Only bits for nodes earlier in the current graph are looked at, so the
  // node's own bit and later bits drop out here.
  function automatic coloring_t color_next_node(input logic [15:0] row);
    int          limit;
    int          node;
    int          hue;
    logic [63:0] used;
    coloring_t   res;
    limit = (count_reg == 0) ? 1 : ((count_reg > MAX_NODES) ? MAX_NODES : int'(count_reg));
    node  = (next_node >= MAX_NODES) ? 0 : next_node;
    used  = '0;
    for (int q = 0; q < node && q < IN_BITS; q++) begin
      if (row[q]) used[color_mem[q]] = 1'b1;
    end
    hue = 0;
    while (hue < 63 && used[hue]) hue++;
    if (hue > 15) hue = 15;
    color_mem[node] = 4'(hue);
    res.node  = 4'(node);
    res.color = 4'(hue);
    // A counter at or past a freshly lowered count also ends the graph here.
    res.last  = (node + 1 >= limit);
    next_node = res.last ? 0 : node + 1;
    return res;
  endfunction

  function automatic logic [15:0] make_row(input row_mix_t mix);
    case (mix)
      ROW_SPARSE: return 16'($urandom & $urandom & $urandom);
      ROW_DENSE:  return 16'($urandom | $urandom);
      // Nearly complete graphs push the colors toward the top of the range.
      ROW_FULL:   return 16'hFFFF & ~(16'h1 << $urandom_range(15));
      default:    return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
  endtask

  // Returns once no request is queued, offered or waiting for its result.
  // Each request yields exactly one result, so the block is idle by then;
  // the extra wait only lets its output register settle.
  task automatic wait_until_drained();
    do @(posedge clk);
    while (row_queue.size() != 0 || in_tvalid || colorings_due.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // Writes node_count while idle. The predictor takes the new value at the
  // same edge at which the block samples the write enable.
  task automatic set_node_count(input logic [CFG_W-1:0] value);
    wait_until_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    count_reg = value;
    @(posedge clk);
  endtask

  // Request driver. A new row is offered only when the previous one has been
  // taken (or none was offered), so a pending request is never withdrawn.
  // The prediction is made at the edge where the request is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) colorings_due.push_back(color_next_node(in_tdata));
      if (row_queue.size() != 0 && (no_gaps || $urandom_range(99) >= 11)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= row_queue.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor. Every accepted result must match the oldest prediction;
  // out_tready drops in about one cycle of nine unless gaps are switched off.
  always @(posedge clk) begin : result_check
    coloring_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (colorings_due.size() == 0) begin
          report_mismatch("result with no request due, node", int'(out_tdata[3:0]), -1);
        end else begin
          want = colorings_due.pop_front();
          if (out_tdata[3:0] !== want.node)
            report_mismatch("node_index", int'(out_tdata[3:0]), int'(want.node));
          if (out_tdata[7:4] !== want.color)
            report_mismatch("node_color", int'(out_tdata[7:4]), int'(want.color));
          if (out_tlast !== want.last)
            report_mismatch("last_node", int'(out_tlast), int'(want.last));
        end
      end
      out_tready <= no_gaps || ($urandom_range(99) >= 11);
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("testbench: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus: directed cases first, then random graphs under many counts.
  initial begin : stimulus
    int             rows_sent;
    int             phase;
    int             eff;
    int             rows;
    logic [CFG_W-1:0] count;
    row_mix_t       mix;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Complete graph at the reset count of 16: node n must get color n, the
    // rows also carry the node's own bit and all later bits, which must not
    // matter, and node 15 closes the graph.
    repeat (16) row_queue.push_back(16'hFFFF);

    // Zero count acts as one: every request is node 0, color 0, last.
    set_node_count(5'd0);
    row_queue.push_back(16'hFFFF);
    row_queue.push_back(16'h0000);

    // Lowering the count mid-graph: after three nodes of a 16-node graph the
    // count drops to 2, so the fourth node is last and the counter wraps.
    set_node_count(5'd16);
    row_queue.push_back(16'h0000);
    row_queue.push_back(16'h0001);
    row_queue.push_back(16'h8003);
    set_node_count(5'd2);
    row_queue.push_back(16'h0007);
    row_queue.push_back(16'h0001);

    // Random graphs. Most phases send whole graphs; some stop partway so the
    // next count write lands mid-graph, raising or lowering the count. The
    // drain before each write also holds the sender until all results are in.
    rows_sent = 0;
    phase     = 0;
    while (rows_sent < RANDOM_ROWS) begin
      if (phase == 0) begin
        count = 5'd31;
      end else begin
        case ($urandom_range(19))
          0:       count = 5'd0;
          1:       count = CFG_W'($urandom_range(17, 31));
          2:       count = 5'd1;
          default: count = CFG_W'($urandom_range(2, 16));
        endcase
      end
      set_node_count(count);
      // A long stretch with neither side idling.
      no_gaps = (rows_sent >= 700 && rows_sent < 1000);
      eff = (count == 0) ? 1 : ((count > MAX_NODES) ? MAX_NODES : int'(count));
      repeat ($urandom_range(1, 4)) begin
        mix  = row_mix_t'($urandom_range(3));
        rows = ($urandom_range(9) == 0) ? $urandom_range(1, eff) : eff;
        repeat (rows) row_queue.push_back(make_row(mix));
        rows_sent += rows;
      end
      phase++;
    end

    wait_until_drained();
    no_gaps = 1'b0;
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
